@@ rtl/stream_find_replace_assert.svh @@
// ----------------------------------------------------------------------------
// stream_find_replace assertion macros
// Concurrent checks disabled while reset is high; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and helpers of the stream find/replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int MAX_PATTERN   = 8;
   localparam int MAX_REPLACE   = 8;
   localparam int SCRATCH_BYTES = 65536;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 64;
   localparam int LEN_W     = 4;
   localparam int CNT_W     = LEN_W + 1;
   localparam int LIMIT_W   = 16;
   localparam int SUM_W     = LIMIT_W + 1;
   localparam int SC_W      = $clog2(SCRATCH_BYTES);
   localparam int WC_W      = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W     = $clog2(MAX_REPLACE);
   localparam int CSR_IDX_W = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_BYTES = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT     = CSR_IDX_W'(4);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = {LIMIT_W{1'b1}};
   localparam logic [SC_W-1:0]    SCRATCH_LAST = SC_W'(SCRATCH_BYTES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPL,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH,
      ACT_HALT,
      ACT_REPLACE,
      ACT_EMIT,
      ACT_END
   } act_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              end_of_text;
      logic              truncated;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] top);
      return (len > top) ? top : len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/stream_find_replace.sv @@
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming replace-all over a byte string held in a row of window cells.
// ----------------------------------------------------------------------------
// A source byte that leaves the window is registered in the result queue before it appears.
// Throughput: one byte beat per cycle while idle and the result queue has room; a match holds
//   input while the kept replacement bytes are emitted and the pattern bytes shift out of the row.
// An end beat flushes the window one byte per cycle while the queue has room, then ends the text.
// Reset is synchronous: window count, counters and job clear, registers return to defaults.
`default_nettype none
`include "stream_find_replace_assert.svh"

module stream_find_replace (
   input  wire                              clock,
   input  wire                              reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                             req_is_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_has_byte,
   output logic                             rsp_end_of_text,
   output logic                             rsp_truncated,
   input  logic                             csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfr_pkg::WORD_W-1:0]       csr_wdata
);

   logic [sfr_pkg::WORD_W-1:0]   pattern_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]    pattern_len_ff;
   logic [sfr_pkg::WORD_W-1:0]   replace_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]    replace_len_ff;
   logic [sfr_pkg::LIMIT_W-1:0]  out_limit_ff;

   sfr_pkg::state_type           state_ff, state_in;
   logic [sfr_pkg::WC_W-1:0]     wc_ff, wc_in;
   logic [sfr_pkg::SC_W-1:0]     sc_ff, sc_in;
   logic                         stopped_ff, stopped_in;
   logic                         dropped_ff, dropped_in;
   logic [sfr_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [sfr_pkg::LEN_W-1:0]    kept_ff, kept_in;
   logic [sfr_pkg::LEN_W-1:0]    shifts_ff, shifts_in;
   logic                         jtrunc_ff, jtrunc_in;

   logic [sfr_pkg::LEN_W-1:0]    plen, rlen, kept_cnt, span;
   logic [sfr_pkg::SUM_W-1:0]    sum, room;
   logic                         accept, beat_end, trigger, sc_full, repl_fit, sc_kept;
   logic                         matched, job_go, emit_now, shift_now, repl_done, flush_byte;
   sfr_pkg::act_type             act;

   sfr_pkg::cell_ctrl_type       cell_ctrl;
   logic [sfr_pkg::BYTE_W-1:0]   view [sfr_pkg::MAX_PATTERN+1];
   logic [sfr_pkg::MAX_PATTERN:0] match_chain;

   logic                         q_push, q_room;
   sfr_pkg::rsp_type             q_data, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff <= '0;
         pattern_len_ff   <= '0;
         replace_bytes_ff <= '0;
         replace_len_ff   <= '0;
         out_limit_ff     <= sfr_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES: pattern_bytes_ff <= csr_wdata;
            sfr_pkg::CSR_PATTERN_LEN:   pattern_len_ff   <= csr_wdata[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_REPLACE_BYTES: replace_bytes_ff <= csr_wdata;
            sfr_pkg::CSR_REPLACE_LEN:   replace_len_ff   <= csr_wdata[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_OUT_LIMIT:     out_limit_ff     <= csr_wdata[sfr_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign view[sfr_pkg::MAX_PATTERN] = '0;
   assign match_chain[0]             = 1'b1;

   for (genvar i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin : g_cell
      sfr_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .here      (wc_ff == sfr_pkg::WC_W'(i)),
         .use_byte  (sfr_pkg::LEN_W'(i) < plen),
         .in_byte   (req_in_byte),
         .pat_byte  (pattern_bytes_ff[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W]),
         .next_view (view[i+1]),
         .match_in  (match_chain[i]),
         .view      (view[i]),
         .match_out (match_chain[i+1])
      );
   end

   sfr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (q_push),
      .in_data   (q_data),
      .has_room  (q_room),
      .out_valid (rsp_valid),
      .out_data  (q_head),
      .out_stall (rsp_stall)
   );

   assign rsp_out_byte    = q_head.out_byte;
   assign rsp_has_byte    = q_head.has_byte;
   assign rsp_end_of_text = q_head.end_of_text;
   assign rsp_truncated   = q_head.truncated;

   assign req_stall = (state_ff != sfr_pkg::ST_IDLE) || !q_room;
   assign accept    = req_valid && !req_stall;
   assign job_go    = q_room;

   always_comb begin
      plen     = sfr_pkg::clamp_len(pattern_len_ff, sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN));
      rlen     = sfr_pkg::clamp_len(replace_len_ff, sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE));
      beat_end = req_is_end || (req_in_byte == '0);
      trigger  = (plen == '0) ||
                 (sfr_pkg::CNT_W'(wc_ff) + sfr_pkg::CNT_W'(1) >= sfr_pkg::CNT_W'(plen));
      sc_full  = (sc_ff == sfr_pkg::SCRATCH_LAST);
      sum      = sfr_pkg::SUM_W'(sc_ff) + sfr_pkg::SUM_W'(rlen);
      repl_fit = (sum < sfr_pkg::SUM_W'(sfr_pkg::SCRATCH_BYTES));
      sc_kept  = (sfr_pkg::SUM_W'(sc_ff) < sfr_pkg::SUM_W'(out_limit_ff));
      room     = sfr_pkg::SUM_W'(out_limit_ff) - sfr_pkg::SUM_W'(sc_ff);
      if (!sc_kept) begin
         kept_cnt = '0;
      end else if (room >= sfr_pkg::SUM_W'(rlen)) begin
         kept_cnt = rlen;
      end else begin
         kept_cnt = sfr_pkg::LEN_W'(room);
      end
      matched    = (plen != '0) && match_chain[sfr_pkg::MAX_PATTERN];
      emit_now   = sfr_pkg::LEN_W'(idx_ff) < kept_ff;
      shift_now  = sfr_pkg::LEN_W'(idx_ff) < shifts_ff;
      span       = (kept_ff > shifts_ff) ? kept_ff : shifts_ff;
      repl_done  = (sfr_pkg::LEN_W'(idx_ff) + sfr_pkg::LEN_W'(1) >= span);
      flush_byte = (wc_ff != '0);

      act = sfr_pkg::ACT_NONE;
      priority if (!accept) begin
         act = sfr_pkg::ACT_NONE;
      end else if (beat_end) begin
         act = sfr_pkg::ACT_END;
      end else if (stopped_ff) begin
         act = sfr_pkg::ACT_NONE;
      end else if (!trigger) begin
         act = sfr_pkg::ACT_PUSH;
      end else if (sc_full) begin
         act = sfr_pkg::ACT_HALT;
      end else if (matched) begin
         act = repl_fit ? sfr_pkg::ACT_REPLACE : sfr_pkg::ACT_HALT;
      end else begin
         act = sfr_pkg::ACT_EMIT;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (act == sfr_pkg::ACT_REPLACE) begin
               state_in = sfr_pkg::ST_REPL;
            end else if (act == sfr_pkg::ACT_END) begin
               state_in = sfr_pkg::ST_FLUSH;
            end
         end
         sfr_pkg::ST_REPL: begin
            if (job_go && repl_done) begin
               state_in = sfr_pkg::ST_IDLE;
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if (job_go && !flush_byte) begin
               state_in = sfr_pkg::ST_IDLE;
            end
         end
         default: state_in = sfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      wc_in      = wc_ff;
      sc_in      = sc_ff;
      stopped_in = stopped_ff;
      dropped_in = dropped_ff;
      idx_in     = idx_ff;
      kept_in    = kept_ff;
      shifts_in  = shifts_ff;
      jtrunc_in  = jtrunc_ff;
      cell_ctrl  = '0;
      q_push     = 1'b0;
      q_data     = '0;
      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            unique case (act)
               sfr_pkg::ACT_PUSH: begin
                  cell_ctrl.push = 1'b1;
                  wc_in          = wc_ff + sfr_pkg::WC_W'(1);
               end
               sfr_pkg::ACT_HALT: begin
                  wc_in      = '0;
                  stopped_in = 1'b1;
                  dropped_in = 1'b1;
               end
               sfr_pkg::ACT_REPLACE: begin
                  cell_ctrl.push = 1'b1;
                  wc_in          = wc_ff + sfr_pkg::WC_W'(1);
                  sc_in          = sfr_pkg::SC_W'(sum);
                  dropped_in     = dropped_ff || (kept_cnt != rlen);
                  kept_in        = kept_cnt;
                  shifts_in      = plen;
                  idx_in         = '0;
                  jtrunc_in      = dropped_ff;
               end
               sfr_pkg::ACT_EMIT: begin
                  cell_ctrl.push  = 1'b1;
                  cell_ctrl.shift = 1'b1;
                  sc_in           = sc_ff + sfr_pkg::SC_W'(1);
                  if (sc_kept) begin
                     q_push = 1'b1;
                     q_data = '{out_byte: view[0], has_byte: 1'b1,
                                end_of_text: 1'b0, truncated: dropped_ff};
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         sfr_pkg::ST_REPL: begin
            if (job_go) begin
               idx_in = idx_ff + sfr_pkg::IDX_W'(1);
               if (emit_now) begin
                  q_push = 1'b1;
                  q_data = '{out_byte: replace_bytes_ff[sfr_pkg::BYTE_W*idx_ff +: sfr_pkg::BYTE_W],
                             has_byte: 1'b1, end_of_text: 1'b0, truncated: jtrunc_ff};
               end
               if (shift_now) begin
                  cell_ctrl.shift = 1'b1;
                  wc_in           = wc_ff - sfr_pkg::WC_W'(1);
               end
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if (job_go) begin
               if (flush_byte) begin
                  if (sc_full) begin
                     wc_in      = '0;
                     stopped_in = 1'b1;
                     dropped_in = 1'b1;
                  end else begin
                     cell_ctrl.shift = 1'b1;
                     wc_in           = wc_ff - sfr_pkg::WC_W'(1);
                     sc_in           = sc_ff + sfr_pkg::SC_W'(1);
                     if (sc_kept) begin
                        q_push = 1'b1;
                        q_data = '{out_byte: view[0], has_byte: 1'b1,
                                   end_of_text: 1'b0, truncated: dropped_ff};
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end else begin
                  q_push     = 1'b1;
                  q_data     = '{out_byte: '0, has_byte: 1'b0,
                                 end_of_text: 1'b1, truncated: dropped_ff};
                  wc_in      = '0;
                  sc_in      = '0;
                  stopped_in = 1'b0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sfr_pkg::ST_IDLE;
         wc_ff      <= '0;
         sc_ff      <= '0;
         stopped_ff <= 1'b0;
         dropped_ff <= 1'b0;
         idx_ff     <= '0;
         kept_ff    <= '0;
         shifts_ff  <= '0;
         jtrunc_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wc_ff      <= wc_in;
         sc_ff      <= sc_in;
         stopped_ff <= stopped_in;
         dropped_ff <= dropped_in;
         idx_ff     <= idx_in;
         kept_ff    <= kept_in;
         shifts_ff  <= shifts_in;
         jtrunc_ff  <= jtrunc_in;
      end
   end

   `SFR_ASSERT_SAME(a_idle_window, clock, reset, state_ff == sfr_pkg::ST_IDLE, wc_ff < sfr_pkg::WC_W'(sfr_pkg::MAX_PATTERN), "window overfull between beats")
   `SFR_ASSERT_SAME(a_stopped_empty, clock, reset, stopped_ff, wc_ff == '0, "window holds bytes after output stopped")
   `SFR_ASSERT_SAME(a_push_room, clock, reset, q_push, q_room, "result beat pushed into a full queue")
   `SFR_ASSERT_NEXT(a_end_clears, clock, reset, (state_ff == sfr_pkg::ST_FLUSH) && job_go && !flush_byte, (state_ff == sfr_pkg::ST_IDLE) && (sc_ff == '0) && !dropped_ff && !stopped_ff, "string state not cleared after end beat")

endmodule

`default_nettype wire

@@ rtl/sfr_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_cell
// One window slot: holds a byte, shows it with a pending push, compares it
// with its pattern byte and passes the running match along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell (
   input  wire                         clock,
   input  sfr_pkg::cell_ctrl_type      ctrl,
   input  logic                        here,
   input  logic                        use_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  in_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  pat_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  next_view,
   input  logic                        match_in,
   output logic [sfr_pkg::BYTE_W-1:0]  view,
   output logic                        match_out
);

   logic [sfr_pkg::BYTE_W-1:0] byte_ff;
   logic [sfr_pkg::BYTE_W-1:0] byte_in;
   logic                       take_new;

   assign take_new  = ctrl.push && here;
   assign view      = take_new ? in_byte : byte_ff;
   assign match_out = match_in && (!use_byte || (view == pat_byte));

   always_comb begin
      if (ctrl.shift) begin
         byte_in = next_view;
      end else begin
         byte_in = view;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

@@ rtl/sfr_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_rsp_queue
// Two-entry result queue between the window logic and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_find_replace_assert.svh"

module sfr_rsp_queue (
   input  wire               clock,
   input  wire               reset,
   input  logic              in_push,
   input  sfr_pkg::rsp_type  in_data,
   output logic              has_room,
   output logic              out_valid,
   output sfr_pkg::rsp_type  out_data,
   input  logic              out_stall
);

   sfr_pkg::rsp_type                  entries_ff [sfr_pkg::QUEUE_DEPTH];
   logic [sfr_pkg::PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sfr_pkg::PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sfr_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              pop;

   assign out_valid = (count_ff != '0);
   assign has_room  = (count_ff != sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
   assign pop       = out_valid && !out_stall;
   assign out_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (in_push) begin
         wr_ptr_in = (wr_ptr_ff == sfr_pkg::PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sfr_pkg::PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sfr_pkg::PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sfr_pkg::PTR_W'(1);
      end
      count_in = count_ff + sfr_pkg::QCNT_W'(in_push) - sfr_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

   `SFR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH), "result queue count out of range")
   `SFR_ASSERT_NEXT(a_count_up, clock, reset, in_push && !pop && has_room, count_ff == $past(count_ff) + sfr_pkg::QCNT_W'(1), "result queue lost a beat")
   `SFR_ASSERT_NEXT(a_count_down, clock, reset, pop && !in_push, count_ff == $past(count_ff) - sfr_pkg::QCNT_W'(1), "result queue repeated a beat")

endmodule

`default_nettype wire
